@@ sv/cpu_lending_allocator_top_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the CPU lending allocator
// Shared property forms, clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef CPU_LENDING_ALLOCATOR_TOP_DEFINES_SVH
`define CPU_LENDING_ALLOCATOR_TOP_DEFINES_SVH

// Same-cycle implication.
`define CLA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cla assertion failed");

// Next-cycle implication.
`define CLA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cla assertion failed");

`endif

@@ sv/cla_pkg.sv @@
// ----------------------------------------------------------------------------
// cla_pkg
// Constants, codes and helpers shared by the CPU lending allocator files.
// ----------------------------------------------------------------------------
package cla_pkg;

  localparam int MaxCpus  = 16;
  localparam int CntW     = 5;
  localparam int IdW      = 4;
  localparam int RowW     = 5;
  localparam int AddrW    = RowW + IdW;
  localparam int TblDepth = (16 + 1) * MaxCpus;
  localparam int EntryW   = IdW + 1;

  localparam logic [RowW-1:0] PoolRow = 5'd16;

  localparam logic [1:0] OpJoin    = 2'd0;
  localparam logic [1:0] OpRelease = 2'd1;
  localparam logic [1:0] OpAcquire = 2'd2;
  localparam logic [1:0] OpCheck   = 2'd3;

  localparam logic CfgNumProcs   = 1'b0;
  localparam logic CfgDefaultCpu = 1'b1;

  // Largest default share for a given requester count (pool size over count).
  function automatic logic [CntW-1:0] max_default(input logic [CntW-1:0] p);
    logic [CntW-1:0] r;
    case (p)
      5'd1: r = 5'd16;
      5'd2: r = 5'd8;
      5'd3: r = 5'd5;
      5'd4: r = 5'd4;
      5'd5: r = 5'd3;
      5'd6, 5'd7, 5'd8: r = 5'd2;
      default: r = 5'd1;
    endcase
    return r;
  endfunction

  function automatic logic [CntW-1:0] min5(input logic [CntW-1:0] a,
                                           input logic [CntW-1:0] b);
    return (a < b) ? a : b;
  endfunction

endpackage

@@ sv/cla_ram.sv @@
// ----------------------------------------------------------------------------
// cla_ram
// Generic single-clock RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module cla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/cpu_lending_allocator_top.sv @@
// ----------------------------------------------------------------------------
// cpu_lending_allocator_top
// Shares a pool of CPU ids between requesters: join, release, acquire and
// check-idle operations on a table of listed ids held in one RAM.
// ----------------------------------------------------------------------------
// One operation at a time: busy_o is high from the accepted start until the
// last result beat has been launched. The table lives in a single RAM and every
// moved entry passes through a read state and a data state, plus a clearing write
// state when it is copied out of the idle pool into a row; acquire also scans the
// requesters, release then writes the idle pool, and each operation ends by
// emitting its result beats. Results appear on valid_o for one cycle each and
// cannot be held off.
// After reset, and on a join by requester 0, the whole table is cleared in a
// pass over all 272 entries while busy_o stays high; configuration writes are
// still taken at any time.
module cpu_lending_allocator_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [1:0]        op_i,
  input  logic [3:0]        requester_i,
  input  logic [4:0]        amount_i,
  input  logic [4:0]        limit_i,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [4:0]        cfg_data_i,
  output logic              valid_o,
  output logic [3:0]        cpu_id_o,
  output logic              cpu_valid_o,
  output logic signed [5:0] count_o,
  output logic              last_o
);

  localparam logic [3:0] SClear = 4'd0;
  localparam logic [3:0] SIdle  = 4'd1;
  localparam logic [3:0] SJoin  = 4'd2;
  localparam logic [3:0] SMRd   = 4'd3;
  localparam logic [3:0] SMDat  = 4'd4;
  localparam logic [3:0] SMZero = 4'd5;
  localparam logic [3:0] SPoolW = 4'd6;
  localparam logic [3:0] SScan  = 4'd7;
  localparam logic [3:0] SEmit  = 4'd8;

  logic [3:0] state_q, state_d;
  logic [4:0] num_procs_q, default_cpus_q;
  logic       join_pend_q, join_pend_d;
  logic [cla_pkg::AddrW-1:0] clr_q, clr_d;

  logic [1:0] op_q, op_d;
  logic [3:0] req_q, req_d;
  logic [4:0] own_q [16];
  logic [4:0] own_d [16];
  logic [4:0] clm_q [16];
  logic [4:0] clm_d [16];
  logic [4:0] idle_q, idle_d;

  logic [4:0] src_row_q, src_row_d, src_col_q, src_col_d;
  logic [4:0] dst_row_q, dst_row_d, dst_col_q, dst_col_d;
  logic [4:0] mn_q, mn_d, mk_q, mk_d;
  logic       zero_q, zero_d, dst_en_q, dst_en_d;
  logic [4:0] fill_q, fill_d, si_q, si_d;
  logic [4:0] pw_base_q, pw_base_d, pw_n_q, pw_n_d;
  logic [4:0] bcnt_q, bcnt_d;
  logic [3:0] ek_q, ek_d;
  logic [5:0] count_q, count_d;
  logic [cla_pkg::EntryW-1:0] buf_q [16];
  logic [cla_pkg::EntryW-1:0] buf_d [16];

  logic       out_valid_q, out_valid_d, out_cv_q, out_cv_d, out_last_q, out_last_d;
  logic [3:0] out_id_q, out_id_d;

  logic                       ram_we;
  logic [cla_pkg::AddrW-1:0]  ram_waddr, ram_raddr;
  logic [cla_pkg::EntryW-1:0] ram_wdata, ram_rdata;

  logic [4:0] p_eff, d_eff;

  always_comb begin
    if (num_procs_q == 5'd0) begin
      p_eff = 5'd1;
    end else if (num_procs_q > 5'd16) begin
      p_eff = 5'd16;
    end else begin
      p_eff = num_procs_q;
    end
    d_eff = cla_pkg::min5(default_cpus_q, cla_pkg::max_default(p_eff));
  end

  always_comb begin
    logic [5:0] have6, sum6;
    logic [4:0] have, c, start, to_idle, cur, need, got, o, room, tmp, cpus, total;
    logic [4:0] own_r, clm_r;
    logic [8:0] jid;
    logic [cla_pkg::EntryW-1:0] e;

    state_d = state_q;     join_pend_d = join_pend_q; clr_d = clr_q;
    op_d = op_q;           req_d = req_q;             own_d = own_q;
    clm_d = clm_q;         idle_d = idle_q;
    src_row_d = src_row_q; src_col_d = src_col_q;
    dst_row_d = dst_row_q; dst_col_d = dst_col_q;
    mn_d = mn_q;           mk_d = mk_q;               zero_d = zero_q;
    dst_en_d = dst_en_q;   fill_d = fill_q;           si_d = si_q;
    pw_base_d = pw_base_q; pw_n_d = pw_n_q;           bcnt_d = bcnt_q;
    ek_d = ek_q;           count_d = count_q;         buf_d = buf_q;
    out_valid_d = 1'b0;    out_cv_d = 1'b0;           out_last_d = 1'b0;
    out_id_d = 4'd0;
    ram_we = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = {src_row_q, src_col_q[3:0]};

    own_r = own_q[requester_i];
    clm_r = clm_q[requester_i];
    have6 = 6'(own_r) + 6'(clm_r);
    have = (have6 > 6'd16) ? 5'd16 : have6[4:0];
    c = cla_pkg::min5(amount_i, have);
    start = have - c;
    to_idle = (c > clm_r) ? (c - clm_r) : 5'd0;
    cur = cla_pkg::min5(amount_i, 5'd16);
    need = (d_eff > cur) ? (d_eff - cur) : 5'd0;
    got = cla_pkg::min5(need, idle_q);
    o = own_r;
    room = 5'd16 - o;
    cpus = cla_pkg::min5(cla_pkg::min5(idle_q, d_eff), cla_pkg::min5(limit_i, room));
    tmp = cla_pkg::min5(own_q[si_q[3:0]] - d_eff, d_eff - fill_q);
    sum6 = 6'(idle_q) + 6'(to_idle);
    jid = 9'(req_q) * 9'(d_eff) + 9'(mk_q);
    total = (bcnt_q == 5'd0) ? 5'd1 : bcnt_q;
    e = buf_q[ek_q];

    case (state_q)
      SClear: begin
        ram_we = 1'b1;
        ram_waddr = clr_q;
        if (clr_q == cla_pkg::AddrW'(cla_pkg::TblDepth - 1)) begin
          clr_d = '0;
          if (join_pend_q) begin
            join_pend_d = 1'b0;
            mk_d = 5'd0;
            state_d = SJoin;
          end else begin
            state_d = SIdle;
          end
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      SIdle: begin
        if (start_i) begin
          op_d = op_i;
          req_d = requester_i;
          bcnt_d = 5'd0;
          ek_d = 4'd0;
          mk_d = 5'd0;
          src_row_d = {1'b0, requester_i};
          dst_row_d = {1'b0, requester_i};
          if ({1'b0, requester_i} >= p_eff) begin
            count_d = 6'd0;
            state_d = SEmit;
          end else begin
            case (op_i)
              cla_pkg::OpJoin: begin
                if (requester_i == 4'd0) begin
                  for (int k = 0; k < 16; k++) begin
                    own_d[k] = 5'd0;
                    clm_d[k] = 5'd0;
                  end
                  idle_d = 5'd0;
                  join_pend_d = 1'b1;
                  clr_d = '0;
                  state_d = SClear;
                end else begin
                  state_d = SJoin;
                end
              end
              cla_pkg::OpRelease: begin
                src_col_d = start;
                mn_d = c;
                zero_d = 1'b1;
                dst_en_d = 1'b0;
                pw_base_d = idle_q;
                pw_n_d = cla_pkg::min5(to_idle, 5'd16 - idle_q);
                idle_d = (sum6 > 6'd16) ? 5'd16 : sum6[4:0];
                own_d[requester_i] = (own_r > c) ? (own_r - c) : 5'd0;
                clm_d[requester_i] = 5'd0;
                count_d = 6'd0;
                state_d = SMRd;
              end
              cla_pkg::OpAcquire: begin
                src_row_d = cla_pkg::PoolRow;
                src_col_d = idle_q - got;
                dst_col_d = cur;
                mn_d = got;
                zero_d = 1'b1;
                dst_en_d = 1'b1;
                idle_d = idle_q - got;
                fill_d = cur + got;
                si_d = 5'd0;
                state_d = SMRd;
              end
              default: begin
                if (clm_r != 5'd0) begin
                  src_col_d = o;
                  mn_d = cla_pkg::min5(clm_r, room);
                  zero_d = 1'b1;
                  dst_en_d = 1'b0;
                  clm_d[requester_i] = 5'd0;
                  count_d = 6'd0 - {1'b0, o};
                  state_d = SMRd;
                end else if (idle_q != 5'd0 && limit_i != 5'd0) begin
                  src_row_d = cla_pkg::PoolRow;
                  src_col_d = idle_q - cpus;
                  dst_col_d = o;
                  mn_d = cpus;
                  zero_d = 1'b1;
                  dst_en_d = 1'b1;
                  own_d[requester_i] = o + cpus;
                  idle_d = idle_q - cpus;
                  count_d = {1'b0, o + cpus};
                  state_d = SMRd;
                end else begin
                  count_d = {1'b0, amount_i};
                  state_d = SEmit;
                end
              end
            endcase
          end
        end
      end
      SJoin: begin
        if (mk_q == d_eff) begin
          own_d[req_q] = d_eff;
          count_d = {1'b0, d_eff};
          bcnt_d = d_eff;
          state_d = SEmit;
        end else begin
          ram_we = 1'b1;
          ram_waddr = {1'b0, req_q, mk_q[3:0]};
          ram_wdata = {1'b1, jid[3:0]};
          buf_d[mk_q[3:0]] = {1'b1, jid[3:0]};
          mk_d = mk_q + 5'd1;
        end
      end
      SMRd: begin
        if (mk_q == mn_q) begin
          case (op_q)
            cla_pkg::OpRelease: begin
              mk_d = 5'd0;
              state_d = SPoolW;
            end
            cla_pkg::OpAcquire: state_d = SScan;
            default: state_d = SEmit;
          endcase
        end else begin
          state_d = SMDat;
        end
      end
      SMDat: begin
        buf_d[bcnt_q[3:0]] = ram_rdata;
        bcnt_d = bcnt_q + 5'd1;
        if (dst_en_q) begin
          ram_we = 1'b1;
          ram_waddr = {dst_row_q, dst_col_q[3:0]};
          ram_wdata = ram_rdata;
          dst_col_d = dst_col_q + 5'd1;
        end else if (zero_q) begin
          ram_we = 1'b1;
          ram_waddr = {src_row_q, src_col_q[3:0]};
        end
        if (dst_en_q && zero_q) begin
          state_d = SMZero;
        end else begin
          src_col_d = src_col_q + 5'd1;
          mk_d = mk_q + 5'd1;
          state_d = SMRd;
        end
      end
      SMZero: begin
        ram_we = 1'b1;
        ram_waddr = {src_row_q, src_col_q[3:0]};
        src_col_d = src_col_q + 5'd1;
        mk_d = mk_q + 5'd1;
        state_d = SMRd;
      end
      SPoolW: begin
        if (mk_q == pw_n_q) begin
          state_d = SEmit;
        end else begin
          ram_we = 1'b1;
          ram_waddr = {cla_pkg::PoolRow, 4'(pw_base_q + mk_q)};
          ram_wdata = buf_q[mk_q[3:0]];
          mk_d = mk_q + 5'd1;
        end
      end
      SScan: begin
        if (fill_q >= d_eff || si_q == p_eff) begin
          own_d[req_q] = fill_q;
          count_d = {1'b0, fill_q};
          state_d = SEmit;
        end else if (own_q[si_q[3:0]] <= d_eff) begin
          si_d = si_q + 5'd1;
        end else begin
          // Borrow from this requester's excess, up to our shortfall, into the tail of our row.
          src_row_d = si_q;
          src_col_d = own_q[si_q[3:0]] - tmp;
          dst_col_d = fill_q;
          mn_d = tmp;
          mk_d = 5'd0;
          zero_d = 1'b0;
          dst_en_d = 1'b1;
          sum6 = 6'(clm_q[si_q[3:0]]) + 6'(tmp);
          clm_d[si_q[3:0]] = (sum6 > 6'd16) ? 5'd16 : sum6[4:0];
          own_d[si_q[3:0]] = own_q[si_q[3:0]] - tmp;
          fill_d = fill_q + tmp;
          state_d = SMRd;
        end
      end
      SEmit: begin
        out_valid_d = 1'b1;
        out_cv_d = (bcnt_q != 5'd0) && e[cla_pkg::EntryW-1];
        out_id_d = out_cv_d ? e[3:0] : 4'd0;
        out_last_d = ({1'b0, ek_q} == total - 5'd1);
        if (out_last_d) begin
          state_d = SIdle;
        end else begin
          ek_d = ek_q + 4'd1;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClear;
      join_pend_q <= 1'b0;
      clr_q <= '0;
      num_procs_q <= 5'd1;
      default_cpus_q <= 5'd1;
      idle_q <= 5'd0;
      for (int k = 0; k < 16; k++) begin
        own_q[k] <= 5'd0;
        clm_q[k] <= 5'd0;
      end
      out_valid_q <= 1'b0;
      out_last_q <= 1'b0;
    end else begin
      state_q <= state_d;
      join_pend_q <= join_pend_d;
      clr_q <= clr_d;
      idle_q <= idle_d;
      own_q <= own_d;
      clm_q <= clm_d;
      out_valid_q <= out_valid_d;
      out_last_q <= out_last_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == cla_pkg::CfgNumProcs) begin
          num_procs_q <= cfg_data_i;
        end else begin
          default_cpus_q <= cfg_data_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;
    req_q <= req_d;
    src_row_q <= src_row_d;
    src_col_q <= src_col_d;
    dst_row_q <= dst_row_d;
    dst_col_q <= dst_col_d;
    mn_q <= mn_d;
    mk_q <= mk_d;
    zero_q <= zero_d;
    dst_en_q <= dst_en_d;
    fill_q <= fill_d;
    si_q <= si_d;
    pw_base_q <= pw_base_d;
    pw_n_q <= pw_n_d;
    bcnt_q <= bcnt_d;
    ek_q <= ek_d;
    count_q <= count_d;
    buf_q <= buf_d;
    out_cv_q <= out_cv_d;
    out_id_q <= out_id_d;
  end

  cla_ram #(
    .WIDTH(cla_pkg::EntryW),
    .DEPTH(cla_pkg::TblDepth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign busy_o      = (state_q != SIdle);
  assign valid_o     = out_valid_q;
  assign cpu_id_o    = out_id_q;
  assign cpu_valid_o = out_cv_q;
  assign count_o     = count_q;
  assign last_o      = out_last_q;

endmodule

@@ sv/cla_checker.sv @@
// ----------------------------------------------------------------------------
// cla_checker
// Port-level checks on the CPU lending allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "cpu_lending_allocator_top_defines.svh"

module cla_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic valid_o,
  input logic cpu_valid_o,
  input logic last_o
);

  `CLA_ASSERT_NXT(a_accept_busy, start_i && !busy_o, busy_o)
  `CLA_ASSERT_NXT(a_beats_contig, valid_o && !last_o, valid_o)
  `CLA_ASSERT_IMP(a_last_strobed, last_o, valid_o)
  `CLA_ASSERT_IMP(a_id_strobed, cpu_valid_o, valid_o)

endmodule

bind cpu_lending_allocator_top cla_checker u_cla_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .valid_o     (valid_o),
  .cpu_valid_o (cpu_valid_o),
  .last_o      (last_o)
);

@@ test/cpu_lending_allocator_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// CPU lending allocator checker
// Watches the operation, configuration and result channels, keeps its own
// copy of the CPU table, counts and pool, and compares every result beat.
// ----------------------------------------------------------------------------
module cpu_lending_allocator_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  logic [1:0]        op_i,
  input  logic [3:0]        requester_i,
  input  logic [4:0]        amount_i,
  input  logic [4:0]        limit_i,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [4:0]        cfg_data_i,
  input  logic              valid_i,
  input  logic [3:0]        cpu_id_i,
  input  logic              cpu_valid_i,
  input  logic signed [5:0] count_i,
  input  logic              last_i,
  output int                pending_o,
  output int                fail_count_o
);

  typedef struct packed {
    logic [3:0] cpu_id;
    logic       cpu_valid;
    logic [5:0] count;
    logic       last;
  } beat_t;

  beat_t      expected_beats[$];
  // Entry bit 8 marks a filled slot; row 16 is the idle pool.
  logic [8:0] cpu_rows[17][16];
  int         owned_n[16];
  int         claimed_n[16];
  int         idle_n;
  int         cfg_procs;
  int         cfg_default;

  function automatic int umin(int a, int b);
    return (a < b) ? a : b;
  endfunction

  task automatic report(input string what, input logic [11:0] got, input logic [11:0] want);
    $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    fail_count_o++;
  endtask

  task automatic list_beats(input logic [8:0] lst[16], input int n, input int cnt);
    beat_t b;
    int    total;
    total = (n > 0) ? n : 1;
    for (int k = 0; k < total; k++) begin
      b.cpu_valid = (n > 0) ? lst[k][8] : 1'b0;
      b.cpu_id    = b.cpu_valid ? lst[k][3:0] : 4'd0;
      b.count     = cnt[5:0];
      b.last      = (k + 1 == total);
      expected_beats.push_back(b);
    end
  endtask

  task automatic predict_op(input logic [1:0] op, input int r, input int amount, input int lim);
    logic [8:0] lst[16];
    int p, d, have, c, st, to_idle, cur, need, got, i, tmp, o, n, cpus;
    p = (cfg_procs < 1) ? 1 : ((cfg_procs > 16) ? 16 : cfg_procs);
    d = umin(cfg_default, 16 / p);
    n = 0;
    for (int k = 0; k < 16; k++) lst[k] = '0;
    if (r >= p) begin
      list_beats(lst, 0, 0);
      return;
    end
    case (op)
      cla_pkg::OpJoin: begin
        if (r == 0) begin
          for (int a = 0; a < 17; a++) for (int b = 0; b < 16; b++) cpu_rows[a][b] = '0;
          for (int a = 0; a < 16; a++) begin
            owned_n[a] = 0;
            claimed_n[a] = 0;
          end
          idle_n = 0;
        end
        for (int k = 0; k < d; k++) begin
          cpu_rows[r][k] = {1'b1, 8'((r * d + k) & 8'hff)};
          lst[k] = cpu_rows[r][k];
        end
        owned_n[r] = d;
        list_beats(lst, d, d);
      end
      cla_pkg::OpRelease: begin
        have = umin(owned_n[r] + claimed_n[r], 16);
        c = umin(amount, have);
        st = have - c;
        to_idle = (c > claimed_n[r]) ? c - claimed_n[r] : 0;
        for (int k = 0; k < c; k++) begin
          lst[k] = cpu_rows[r][st + k];
          cpu_rows[r][st + k] = '0;
        end
        for (int k = 0; k < to_idle; k++)
          if (idle_n + k < 16) cpu_rows[16][idle_n + k] = lst[k];
        idle_n = umin(idle_n + to_idle, 16);
        owned_n[r] = (owned_n[r] > c) ? owned_n[r] - c : 0;
        claimed_n[r] = 0;
        list_beats(lst, c, 0);
      end
      cla_pkg::OpAcquire: begin
        cur = umin(amount, 16);
        need = (d > cur) ? d - cur : 0;
        got = umin(need, idle_n);
        idle_n -= got;
        for (int k = 0; k < got; k++) begin
          cpu_rows[r][cur + k] = cpu_rows[16][idle_n + k];
          cpu_rows[16][idle_n + k] = '0;
        end
        i = 0;
        // Borrow the surplus of requesters above their default share, in index order.
        while (cur + got < d && i < p) begin
          while (i < p && owned_n[i] <= d) i++;
          if (i == p) break;
          tmp = umin(owned_n[i] - d, d - cur - got);
          for (int k = 0; k < tmp; k++) lst[k] = cpu_rows[i][owned_n[i] - tmp + k];
          for (int k = 0; k < tmp; k++) cpu_rows[r][cur + got + k] = lst[k];
          claimed_n[i] = umin(claimed_n[i] + tmp, 16);
          owned_n[i] -= tmp;
          got += tmp;
        end
        for (int k = 0; k < got; k++) lst[k] = cpu_rows[r][cur + k];
        owned_n[r] = cur + got;
        list_beats(lst, got, cur + got);
      end
      default: begin
        if (claimed_n[r] > 0) begin
          o = owned_n[r];
          for (int k = 0; k < claimed_n[r]; k++)
            if (o + k < 16) begin
              lst[n] = cpu_rows[r][o + k];
              n++;
              cpu_rows[r][o + k] = '0;
            end
          claimed_n[r] = 0;
          list_beats(lst, n, -o);
        end else if (idle_n > 0 && lim > 0) begin
          o = owned_n[r];
          cpus = umin(umin(idle_n, d), umin(lim, 16 - o));
          for (int k = 0; k < cpus; k++) begin
            lst[k] = cpu_rows[16][idle_n - cpus + k];
            cpu_rows[r][o + k] = lst[k];
            cpu_rows[16][idle_n - cpus + k] = '0;
          end
          owned_n[r] = o + cpus;
          idle_n -= cpus;
          list_beats(lst, cpus, owned_n[r]);
        end else begin
          list_beats(lst, 0, amount);
        end
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    beat_t want;
    if (!rst_ni) begin
      for (int a = 0; a < 17; a++) for (int b = 0; b < 16; b++) cpu_rows[a][b] = '0;
      for (int a = 0; a < 16; a++) begin
        owned_n[a] = 0;
        claimed_n[a] = 0;
      end
      idle_n = 0;
      cfg_procs = 1;
      cfg_default = 1;
      expected_beats.delete();
      pending_o = 0;
    end else begin
      if (valid_i) begin
        if (expected_beats.size() == 0) begin
          report("unexpected beat", {cpu_id_i, cpu_valid_i, count_i, last_i}, '0);
        end else begin
          want = expected_beats.pop_front();
          if (cpu_id_i !== want.cpu_id) report("cpu_id", cpu_id_i, want.cpu_id);
          if (cpu_valid_i !== want.cpu_valid) report("cpu_valid", cpu_valid_i, want.cpu_valid);
          if (count_i !== want.count) report("count", count_i, want.count);
          if (last_i !== want.last) report("last", last_i, want.last);
        end
      end
      // The operation sees the configuration as it stood before this edge.
      if (start_i && !busy_i) predict_op(op_i, requester_i, amount_i, limit_i);
      if (cfg_we_i) begin
        if (cfg_idx_i == cla_pkg::CfgNumProcs) cfg_procs = cfg_data_i;
        else cfg_default = cfg_data_i;
      end
      pending_o = expected_beats.size();
    end
  end

  initial fail_count_o = 0;

endmodule

@@ test/cpu_lending_allocator_top_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// CPU lending allocator testbench
// Drives join, release, acquire and check-idle operations under several pool
// configurations and sender idling patterns; a checker module predicts and
// compares every result beat.
// ----------------------------------------------------------------------------
module cpu_lending_allocator_top_test;

  logic              clk_i;
  logic              rst_ni;
  logic              start_i;
  logic              busy_o;
  logic [1:0]        op_i;
  logic [3:0]        requester_i;
  logic [4:0]        amount_i;
  logic [4:0]        limit_i;
  logic              cfg_we_i;
  logic              cfg_idx_i;
  logic [4:0]        cfg_data_i;
  logic              valid_o;
  logic [3:0]        cpu_id_o;
  logic              cpu_valid_o;
  logic signed [5:0] count_o;
  logic              last_o;
  int                pending;
  int                fail_count;
  int                idle_pct;
  int                procs_eff;

  cpu_lending_allocator_top dut (.*);

  cpu_lending_allocator_checker checker_i (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .op_i, .requester_i, .amount_i,
    .limit_i, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .valid_i(valid_o), .cpu_id_i(cpu_id_o),
    .cpu_valid_i(cpu_valid_o), .count_i(count_o), .last_i(last_o),
    .pending_o(pending), .fail_count_o(fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Called at a falling edge; returns at the falling edge after acceptance,
  // leaving start high so that a following beat can go straight on.
  task automatic issue(input logic [1:0] op, input int r, input int amount, input int lim);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start_i = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    start_i = 1'b1;
    op_i = op;
    requester_i = r[3:0];
    amount_i = amount[4:0];
    limit_i = lim[4:0];
    while (busy_o) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain();
    start_i = 1'b0;
    while (pending != 0 || busy_o) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic configure(input int procs, input int dflt);
    drain();
    cfg_we_i = 1'b1;
    cfg_idx_i = cla_pkg::CfgNumProcs;
    cfg_data_i = procs[4:0];
    @(negedge clk_i);
    cfg_idx_i = cla_pkg::CfgDefaultCpu;
    cfg_data_i = dflt[4:0];
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    procs_eff = (procs < 1) ? 1 : ((procs > 16) ? 16 : procs);
  endtask

  task automatic join_all();
    for (int r = 0; r < procs_eff; r++) issue(cla_pkg::OpJoin, r, 0, 0);
  endtask

  task automatic random_ops(input int n);
    int sel, r;
    logic [1:0] op;
    for (int k = 0; k < n; k++) begin
      sel = $urandom_range(99);
      r = (sel < 8) ? $urandom_range(15) : $urandom_range(procs_eff - 1);
      // Joins by requester 0 clear the table, so keep them rare.
      op = 2'($urandom_range(3));
      if (op == cla_pkg::OpJoin && r == 0 && $urandom_range(3) != 0) op = cla_pkg::OpAcquire;
      issue(op, r, (sel > 92) ? $urandom_range(31) : $urandom_range(16),
            (sel > 85) ? $urandom_range(31) : $urandom_range(4));
      if (k == n / 2 && n > 20) drain();
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    start_i = 1'b0;
    op_i = cla_pkg::OpJoin;
    requester_i = '0;
    amount_i = '0;
    limit_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = cla_pkg::CfgNumProcs;
    cfg_data_i = '0;
    idle_pct = 0;
    procs_eff = 1;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed beats at the reset configuration and at the extremes.
    issue(cla_pkg::OpCheck, 0, 5, 3);
    issue(cla_pkg::OpJoin, 0, 0, 0);
    issue(cla_pkg::OpJoin, 1, 0, 0);
    issue(cla_pkg::OpRelease, 0, 31, 0);
    issue(cla_pkg::OpCheck, 0, 0, 31);
    configure(4, 31);
    join_all();
    issue(cla_pkg::OpRelease, 3, 2, 0);
    issue(cla_pkg::OpAcquire, 1, 31, 0);
    issue(cla_pkg::OpAcquire, 2, 0, 0);
    issue(cla_pkg::OpAcquire, 0, 0, 0);
    issue(cla_pkg::OpCheck, 0, 2, 0);
    issue(cla_pkg::OpCheck, 1, 4, 16);
    issue(cla_pkg::OpCheck, 1, 4, 16);
    issue(cla_pkg::OpRelease, 1, 0, 0);
    configure(0, 0);
    issue(cla_pkg::OpJoin, 0, 0, 0);
    issue(cla_pkg::OpAcquire, 0, 0, 0);
    issue(cla_pkg::OpJoin, 15, 0, 0);

    idle_pct = 0;
    configure(16, 1);
    join_all();
    random_ops(25);
    idle_pct = 71;
    configure(1, 16);
    join_all();
    random_ops(25);
    idle_pct = 0;
    configure(3, 5);
    join_all();
    random_ops(25);
    idle_pct = 32;
    configure(31, 2);
    join_all();
    random_ops(25);
    idle_pct = 71;
    configure(2, 8);
    join_all();
    random_ops(25);

    drain();
    if (fail_count == 0) begin
      $display("cpu_lending_allocator_top test passed");
    end else begin
      $display("cpu_lending_allocator_top test failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("cpu_lending_allocator_top test failed");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+sv
sv/cla_pkg.sv
sv/cla_ram.sv
sv/cpu_lending_allocator_top.sv
sv/cla_checker.sv
test/cpu_lending_allocator_checker.sv
test/cpu_lending_allocator_top_test.sv
